/* hdl/i2cmb_pkg.sv */
package i2cmb_pkg;

	// Bytes in each bank of each store.
	localparam int BUFFER_BYTES = 32;
	localparam int IDX_W        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int ADDR_W       = IDX_W + 1;
	localparam int STORE_DEPTH  = 2 ** ADDR_W;

	localparam int REQ_W   = 3;
	localparam int LIDX_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int PTR_W   = 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADDR_MATCH    = 3'd0,
		REQ_STOP          = 3'd1,
		REQ_MASTER_READ   = 3'd2,
		REQ_MASTER_WRITE  = 3'd3,
		REQ_LOCAL_TX_LOAD = 3'd4,
		REQ_LOCAL_RX_READ = 3'd5
	} req_code_t;

	localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

	// Contents of an entry that has not been written since reset.
	function automatic logic [BYTE_W-1:0] reset_byte(input logic bank,
		input logic [PTR_W-1:0] idx);
		return bank ? idx : FILL_BYTE;
	endfunction

	// True when an index lies inside one bank.
	function automatic logic in_buffer(input logic [PTR_W-1:0] idx);
		return ({1'b0, idx} < 9'(BUFFER_BYTES));
	endfunction

endpackage

/* hdl/i2cmb_req_if.sv */
interface i2cmb_req_if
	import i2cmb_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic              second_address;
	logic [BYTE_W-1:0] data_byte;
	logic              local_bank;
	logic [LIDX_W-1:0] local_index;

	modport source(output valid, req_type, second_address, data_byte, local_bank,
		local_index, input ready);
	modport sink(input valid, req_type, second_address, data_byte, local_bank,
		local_index, output ready);
endinterface

/* hdl/i2cmb_rsp_if.sv */
interface i2cmb_rsp_if
	import i2cmb_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              past_end;

	modport source(output valid, read_byte, past_end, input ready);
	modport sink(input valid, read_byte, past_end, output ready);
endinterface

/* hdl/dual_address_i2c_slave_mailbox_top.sv */
// Channel  Modport  Word
// req      sink     req_type, second_address, data_byte, local_bank, local_index
// rsp      source   read_byte, past_end (one word per master read or local rx read)
//
// One request word is taken per cycle while req is not stalled; a reply goes through
// the synchronous read of the transmit or receive store and then through the output
// register. Reset brings every store entry back to its initial byte at once through a
// valid bit per entry, so requests are taken straight after reset.
// While the output register is full and not taken, a held read result stops req.
module dual_address_i2c_slave_mailbox_top
	import i2cmb_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	i2cmb_req_if.sink     req,
	i2cmb_rsp_if.source   rsp
);

	logic              accept;
	logic              advance;
	logic [PTR_W-1:0]  ptr_q;
	logic              loaded_q;
	logic              bank_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] tx_wr_addr;
	logic [ADDR_W-1:0] rx_wr_addr;
	logic              tx_we;
	logic              rx_we;
	logic [PTR_W-1:0]  local_idx;
	logic              has_result;
	logic              rd_bank;
	logic [PTR_W-1:0]  rd_idx;
	logic              rd_past;

	logic [BYTE_W-1:0] tx_mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rx_mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] tx_vld_q;
	logic [STORE_DEPTH-1:0] rx_vld_q;

	logic              v_s1;
	logic              sel_rx_s1;
	logic              past_s1;
	logic              bank_s1;
	logic [PTR_W-1:0]  idx_s1;
	logic [BYTE_W-1:0] tx_rd_s1;
	logic [BYTE_W-1:0] rx_rd_s1;
	logic              txv_s1;
	logic              rxv_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] read_byte_q;
	logic              past_end_q;
	logic [BYTE_W-1:0] stored_byte;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !v_s1 || advance;
	assign accept    = req.valid && req.ready;

	assign local_idx = {{(PTR_W-LIDX_W){1'b0}}, req.local_index};

	always_comb begin
		has_result = 1'b0;
		rd_bank    = bank_q;
		rd_idx     = ptr_q;
		case (req.req_type)
			REQ_MASTER_READ: begin
				has_result = 1'b1;
			end
			REQ_LOCAL_RX_READ: begin
				has_result = 1'b1;
				rd_bank    = req.local_bank;
				rd_idx     = local_idx;
			end
			default: begin
			end
		endcase
	end

	assign rd_past    = !in_buffer(rd_idx);
	assign rd_addr    = {rd_bank, rd_idx[IDX_W-1:0]};
	assign tx_wr_addr = {req.local_bank, local_idx[IDX_W-1:0]};
	assign rx_wr_addr = {bank_q, ptr_q[IDX_W-1:0]};
	assign tx_we = accept && (req.req_type == REQ_LOCAL_TX_LOAD) && in_buffer(local_idx);
	assign rx_we = accept && (req.req_type == REQ_MASTER_WRITE) && loaded_q
		&& in_buffer(ptr_q);

	// Pointer, pointer-loaded flag and active bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			loaded_q <= 1'b0;
			bank_q   <= 1'b0;
		end else if (accept) begin
			case (req.req_type)
				REQ_ADDR_MATCH: begin
					bank_q <= req.second_address;
					ptr_q  <= '0;
				end
				REQ_STOP: begin
					loaded_q <= 1'b0;
				end
				REQ_MASTER_READ: begin
					ptr_q <= ptr_q + 1'b1;
				end
				REQ_MASTER_WRITE: begin
					if (!loaded_q) begin
						ptr_q    <= req.data_byte;
						loaded_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stores: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wr_addr] <= req.data_byte;
		end
		if (rx_we) begin
			rx_mem[rx_wr_addr] <= req.data_byte;
		end
		if (accept) begin
			tx_rd_s1 <= tx_mem[rd_addr];
			rx_rd_s1 <= rx_mem[rd_addr];
		end
	end

	// An entry whose valid bit is clear still holds its initial byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_vld_q <= '0;
			rx_vld_q <= '0;
		end else begin
			if (tx_we) begin
				tx_vld_q[tx_wr_addr] <= 1'b1;
			end
			if (rx_we) begin
				rx_vld_q[rx_wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= has_result;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_rx_s1 <= (req.req_type == REQ_LOCAL_RX_READ);
			past_s1   <= rd_past;
			bank_s1   <= rd_bank;
			idx_s1    <= rd_idx;
			txv_s1    <= tx_vld_q[rd_addr];
			rxv_s1    <= rx_vld_q[rd_addr];
		end
	end

	always_comb begin
		if (sel_rx_s1) begin
			stored_byte = rxv_s1 ? rx_rd_s1 : reset_byte(bank_s1, idx_s1);
		end else begin
			stored_byte = txv_s1 ? tx_rd_s1 : reset_byte(bank_s1, idx_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			read_byte_q <= past_s1 ? '0 : stored_byte;
			past_end_q  <= past_s1;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_byte = read_byte_q;
	assign rsp.past_end  = past_end_q;

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (v_s1 && out_valid_q && !rsp.ready))
		else $error("request port stalled without a held result");

	a_read_moves_pointer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_MASTER_READ) |=> ptr_q == $past(ptr_q) + 1'b1)
		else $error("master read did not advance the pointer");

	a_match_clears_pointer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_ADDR_MATCH) |=> ptr_q == '0)
		else $error("address match did not clear the pointer");

	a_stop_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_STOP) |=> !loaded_q)
		else $error("stop did not clear the pointer-loaded flag");

	a_past_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.past_end) |-> rsp.read_byte == '0)
		else $error("past-end reply carries a non-zero byte");

endmodule

/* dv/tb_top.sv */
module tb_top;
	import i2cmb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic              second_address;
		logic [BYTE_W-1:0] data_byte;
		logic              local_bank;
		logic [LIDX_W-1:0] local_index;
	} req_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              past_end;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	i2cmb_req_if req_ch();
	i2cmb_rsp_if rsp_ch();

	dual_address_i2c_slave_mailbox_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	req_word_t pending_words[$];
	reply_t    expected_replies[$];
	req_word_t offered_word;
	int        idle_pct = 36;
	int        error_count = 0;
	logic      hold_arm = 1'b0;
	logic      hold_spent = 1'b0;
	int        hold_left = 0;

	// Mirror of the mailbox contents and bus-side state.
	logic [BYTE_W-1:0] tx_mirror [2][BUFFER_BYTES];
	logic [BYTE_W-1:0] rx_mirror [2][BUFFER_BYTES];
	logic [PTR_W-1:0]  bus_pointer;
	logic              pointer_set;
	logic              bus_bank;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic void clear_mirror();
		for (int i = 0; i < BUFFER_BYTES; i++) begin
			tx_mirror[0][i] = 8'hFF;
			rx_mirror[0][i] = 8'hFF;
			tx_mirror[1][i] = BYTE_W'(i);
			rx_mirror[1][i] = BYTE_W'(i);
		end
		bus_pointer = '0;
		pointer_set = 1'b0;
		bus_bank    = 1'b0;
	endfunction

	// Updates the mirror with one accepted word and queues the reply it should cause.
	function automatic void apply_request(input req_word_t w);
		reply_t r;
		case (w.req_type)
			REQ_ADDR_MATCH: begin
				bus_bank    = w.second_address;
				bus_pointer = '0;
			end
			REQ_STOP: pointer_set = 1'b0;
			REQ_MASTER_READ: begin
				if (int'(bus_pointer) < BUFFER_BYTES) begin
					r.read_byte = tx_mirror[bus_bank][IDX_W'(bus_pointer)];
					r.past_end  = 1'b0;
				end else begin
					r.read_byte = '0;
					r.past_end  = 1'b1;
				end
				expected_replies.push_back(r);
				bus_pointer = bus_pointer + 1'b1;
			end
			REQ_MASTER_WRITE: begin
				if (!pointer_set) begin
					bus_pointer = w.data_byte;
					pointer_set = 1'b1;
				end else begin
					if (int'(bus_pointer) < BUFFER_BYTES)
						rx_mirror[bus_bank][IDX_W'(bus_pointer)] = w.data_byte;
					bus_pointer = bus_pointer + 1'b1;
				end
			end
			REQ_LOCAL_TX_LOAD: begin
				if (int'(w.local_index) < BUFFER_BYTES)
					tx_mirror[w.local_bank][w.local_index] = w.data_byte;
			end
			REQ_LOCAL_RX_READ: begin
				if (int'(w.local_index) < BUFFER_BYTES) begin
					r.read_byte = rx_mirror[w.local_bank][w.local_index];
					r.past_end  = 1'b0;
				end else begin
					r.read_byte = '0;
					r.past_end  = 1'b1;
				end
				expected_replies.push_back(r);
			end
			default: ;
		endcase
	endfunction

	function automatic req_word_t fresh_word(input logic [REQ_W-1:0] kind);
		req_word_t w;
		w.req_type       = kind;
		w.second_address = 1'($urandom_range(0, 1));
		w.data_byte      = BYTE_W'($urandom_range(0, 255));
		w.local_bank     = 1'($urandom_range(0, 1));
		w.local_index    = LIDX_W'($urandom_range(0, 31));
		return w;
	endfunction

	function automatic void push_word(input logic [REQ_W-1:0] kind, input logic sec,
		input logic [BYTE_W-1:0] data, input logic lbank, input logic [LIDX_W-1:0] lidx);
		req_word_t w;
		w.req_type       = kind;
		w.second_address = sec;
		w.data_byte      = data;
		w.local_bank     = lbank;
		w.local_index    = lidx;
		pending_words.push_back(w);
	endfunction

	// Mostly complete bus transfers with random content, some local traffic and some noise.
	function automatic void push_random(input int count);
		int pushed = 0;
		int pick;
		int ops;
		req_word_t w;
		while (pushed < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				w = fresh_word(REQ_ADDR_MATCH);
				pending_words.push_back(w);
				pushed++;
				if ($urandom_range(0, 99) < 70) begin
					w = fresh_word(REQ_MASTER_WRITE);
					if ($urandom_range(0, 99) < 75)
						w.data_byte = BYTE_W'($urandom_range(0, BUFFER_BYTES + 3));
					pending_words.push_back(w);
					pushed++;
				end
				ops = $urandom_range(1, 8);
				for (int i = 0; i < ops; i++) begin
					pending_words.push_back(fresh_word($urandom_range(0, 1) ?
						REQ_MASTER_READ : REQ_MASTER_WRITE));
					pushed++;
				end
				if ($urandom_range(0, 99) < 80) begin
					pending_words.push_back(fresh_word(REQ_STOP));
					pushed++;
				end
			end else if (pick < 85) begin
				pending_words.push_back(fresh_word($urandom_range(0, 1) ?
					REQ_LOCAL_TX_LOAD : REQ_LOCAL_RX_READ));
				pushed++;
			end else begin
				pending_words.push_back(fresh_word(REQ_W'($urandom_range(0, 7))));
				pushed++;
			end
		end
	endfunction

	// Request driver: holds a word until it is taken, then offers the next one or idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				apply_request(offered_word);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					offered_word = pending_words.pop_front();
					req_ch.req_type       <= offered_word.req_type;
					req_ch.second_address <= offered_word.second_address;
					req_ch.data_byte      <= offered_word.data_byte;
					req_ch.local_bank     <= offered_word.local_bank;
					req_ch.local_index    <= offered_word.local_index;
					req_ch.valid          <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off of the reply channel, so that the block fills and stalls req.
	always @(posedge clk) begin
		if (hold_arm && !hold_spent) begin
			hold_left  <= 400;
			hold_spent <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Reply monitor: checks each taken word against the oldest prediction.
	always @(posedge clk) begin
		reply_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("unexpected reply, read_byte", int'(rsp_ch.read_byte), 0);
				end else begin
					want = expected_replies.pop_front();
					if (rsp_ch.read_byte !== want.read_byte)
						report_mismatch("read_byte", int'(rsp_ch.read_byte),
							int'(want.read_byte));
					if (rsp_ch.past_end !== want.past_end)
						report_mismatch("past_end", int'(rsp_ch.past_end),
							int'(want.past_end));
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = '0;
		req_ch.second_address = 1'b0;
		req_ch.data_byte      = '0;
		req_ch.local_bank     = 1'b0;
		req_ch.local_index    = '0;
		rsp_ch.ready          = 1'b0;
		clear_mirror();

		// Reset contents of both banks, writes running off the end of a bank,
		// local access, reads past the end, pointer wrap and a flag that survives
		// an address match.
		push_word(REQ_ADDR_MATCH, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_ADDR_MATCH, 1'b1, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'd30, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'hFF, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'hA5, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_STOP, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_LOCAL_RX_READ, 1'b0, 8'h00, 1'b1, 5'd30);
		push_word(REQ_LOCAL_RX_READ, 1'b0, 8'h00, 1'b1, 5'd31);
		push_word(REQ_LOCAL_RX_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_LOCAL_TX_LOAD, 1'b0, 8'h5A, 1'b0, 5'd31);
		push_word(REQ_LOCAL_TX_LOAD, 1'b0, 8'h81, 1'b1, 5'd0);
		push_word(REQ_ADDR_MATCH, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'd31, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_STOP, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'd255, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_READ, 1'b0, 8'h00, 1'b0, 5'd0);
		push_word(REQ_ADDR_MATCH, 1'b1, 8'h00, 1'b0, 5'd0);
		push_word(REQ_MASTER_WRITE, 1'b0, 8'h3C, 1'b0, 5'd0);
		push_word(REQ_LOCAL_RX_READ, 1'b0, 8'h00, 1'b1, 5'd0);
		push_word(3'd6, 1'b1, 8'hFF, 1'b1, 5'd31);
		push_word(3'd7, 1'b0, 8'h00, 1'b0, 5'd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_random(700);
		while (pending_words.size() != 0 || req_ch.valid) @(posedge clk);

		idle_pct <= 0;
		push_random(500);
		while (pending_words.size() != 0 || req_ch.valid) @(posedge clk);

		// The sender keeps going while the reply side is held off.
		hold_arm <= 1'b1;
		push_random(300);
		while (pending_words.size() != 0 || req_ch.valid) @(posedge clk);

		idle_pct <= 36;
		push_random(500);
		while (pending_words.size() != 0 || req_ch.valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (expected_replies.size() != 0)
			report_mismatch("replies still missing", 0, expected_replies.size());
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/i2cmb_pkg.sv
hdl/i2cmb_req_if.sv
hdl/i2cmb_rsp_if.sv
hdl/dual_address_i2c_slave_mailbox_top.sv
dv/tb_top.sv
